// File: rtl/sttu_pkg.sv
// Package: shared constants and types for the smoothed temperature thermostat.
package sttu_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SMOOTH_W    = 16;
    localparam int CHANGE_W    = 8;
    localparam int SP_W        = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int ACC_W       = 26;
    localparam int DIFF_W      = 17;

    localparam logic [SP_W-1:0] SP_MIN   = 10'd320;
    localparam logic [SP_W-1:0] SP_MAX   = 10'd640;
    localparam logic [SP_W-1:0] SP_RESET = 10'd320;

    localparam int GAIN_OLD   = 179;
    localparam int GAIN_NEW   = 77;
    localparam int ROUND_HALF = 128;
    localparam int JUMP_LIMIT = 256;
    localparam int HYST_BAND  = 256;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MISSING = 1'b1;

    typedef struct packed {
        logic signed [SMOOTH_W-1:0] filt;
        logic                       have;
        logic                       high;
    } t_state;

    typedef struct packed {
        logic                       err;
        logic                       above;
        logic signed [CHANGE_W-1:0] change;
        logic signed [SMOOTH_W-1:0] smoothed;
    } t_result;

endpackage

// File: rtl/smoothed_temperature_thermostat_unit.sv
// Top level: smoothed temperature thermostat with stream ports and config writes.
// Takes one sample per cycle when the output side keeps up. A sample passes the input
// register, then the result register, before its result is presented on the output.
// The smoothing update, jump check and hysteresis for an item are resolved in the cycle
// it leaves the input register, so the next sample sees the updated state.
// Register 0 is the setpoint (1/16 degree, clamped to 320..640, write clears the
// high flag); register 1 is sensor_missing, which freezes the state and flags error.
module smoothed_temperature_thermostat_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [11:0] temp_sample
    input  logic [sttu_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] smoothed_temp, [23:16] temp_change, [24] above_setpoint, [25] sensor_error
    output logic [sttu_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [sttu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sttu_pkg::SP_W-1:0]           i_cfg_wdata
);

    logic                                 r_in_valid;
    logic signed [sttu_pkg::SAMPLE_W-1:0] r_in_sample;
    logic                                 r_out_valid;
    sttu_pkg::t_result                    r_out;
    sttu_pkg::t_state                     r_state;
    logic [sttu_pkg::SP_W-1:0]            r_setpoint;
    logic                                 r_sensor_missing;

    sttu_pkg::t_state                     step_state;
    sttu_pkg::t_state                     n_state;
    sttu_pkg::t_result                    n_out;
    logic                                 advance;
    logic                                 in_accept;
    logic [sttu_pkg::SP_W-1:0]            sp_clamped;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign sp_clamped = (i_cfg_wdata < sttu_pkg::SP_MIN) ? sttu_pkg::SP_MIN :
                        (i_cfg_wdata > sttu_pkg::SP_MAX) ? sttu_pkg::SP_MAX : i_cfg_wdata;

    sttu_step u_step (
        .i_state          (r_state),
        .i_sample         (r_in_sample),
        .i_setpoint       (r_setpoint),
        .i_sensor_missing (r_sensor_missing),
        .o_state          (step_state),
        .o_result         (n_out)
    );

    // setpoint write clears the high flag
    always_comb begin
        n_state = r_state;
        if (advance) begin
            n_state = step_state;
        end
        if (i_cfg_wr_en && (i_cfg_idx == sttu_pkg::REG_SETPOINT)) begin
            n_state.high = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state          <= '0;
            r_setpoint       <= sttu_pkg::SP_RESET;
            r_sensor_missing <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    sttu_pkg::REG_SETPOINT: begin
                        r_setpoint <= sp_clamped;
                    end
                    sttu_pkg::REG_SENSOR_MISSING: begin
                        r_sensor_missing <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample <= $signed(i_s_axis_tdata[sttu_pkg::SAMPLE_W-1:0]);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b000000, r_out};

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_setpoint >= sttu_pkg::SP_MIN) && (r_setpoint <= sttu_pkg::SP_MAX))
        else $error("setpoint out of clamp range");

    a_sp_clears_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (i_cfg_idx == sttu_pkg::REG_SETPOINT)) |=> !r_state.high)
        else $error("setpoint write did not clear high flag");

    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.err) |-> (r_out.change == '0))
        else $error("error item carries a change");

    a_have_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_state.have))
        else $error("sample-seen flag dropped");

    a_missing_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_sensor_missing && !i_cfg_wr_en) |=> $stable(r_state))
        else $error("state changed while sensor missing");

endmodule

// File: rtl/sttu_step.sv
// Step logic: smoothing update, jump detection and hysteresis for one item.
module sttu_step (
    input  sttu_pkg::t_state                     i_state,
    input  logic signed [sttu_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [sttu_pkg::SP_W-1:0]            i_setpoint,
    input  logic                                 i_sensor_missing,
    output sttu_pkg::t_state                     o_state,
    output sttu_pkg::t_result                    o_result
);

    logic signed [sttu_pkg::SMOOTH_W-1:0] scaled;
    logic signed [sttu_pkg::DIFF_W-1:0]   diff;
    logic signed [sttu_pkg::ACC_W-1:0]    prod_old;
    logic signed [sttu_pkg::ACC_W-1:0]    prod_new;
    logic signed [sttu_pkg::ACC_W-1:0]    num;
    logic signed [sttu_pkg::SMOOTH_W-1:0] nv;
    logic                                 jump;
    logic signed [sttu_pkg::SMOOTH_W-1:0] filt_new;
    logic signed [sttu_pkg::DIFF_W-1:0]   change_w;
    logic signed [sttu_pkg::DIFF_W-1:0]   sp_hi;
    logic signed [sttu_pkg::DIFF_W-1:0]   sp_lo;
    logic signed [sttu_pkg::DIFF_W-1:0]   filt_ext;
    logic                                 high_set;
    logic                                 high_new;

    assign scaled   = $signed({i_sample, 4'b0000});
    assign diff     = sttu_pkg::DIFF_W'(scaled) - sttu_pkg::DIFF_W'(i_state.filt);
    assign prod_old = sttu_pkg::ACC_W'(i_state.filt)
                      * $signed(sttu_pkg::ACC_W'(sttu_pkg::GAIN_OLD));
    assign prod_new = sttu_pkg::ACC_W'(scaled)
                      * $signed(sttu_pkg::ACC_W'(sttu_pkg::GAIN_NEW));
    assign num      = prod_old + prod_new + $signed(sttu_pkg::ACC_W'(sttu_pkg::ROUND_HALF));
    assign nv       = num[sttu_pkg::SMOOTH_W+7:8];

    assign jump = !i_state.have
                  || (diff > $signed(sttu_pkg::DIFF_W'(sttu_pkg::JUMP_LIMIT)))
                  || (diff < -$signed(sttu_pkg::DIFF_W'(sttu_pkg::JUMP_LIMIT)));

    assign filt_new = jump ? scaled : nv;
    assign change_w = jump ? '0
                           : sttu_pkg::DIFF_W'(nv) - sttu_pkg::DIFF_W'(i_state.filt);

    assign sp_hi    = $signed({3'b000, i_setpoint, 4'b0000});
    assign sp_lo    = sp_hi - $signed(sttu_pkg::DIFF_W'(sttu_pkg::HYST_BAND));
    assign filt_ext = sttu_pkg::DIFF_W'(filt_new);
    assign high_set = i_state.high || (filt_ext > sp_hi);
    assign high_new = high_set && !(filt_ext < sp_lo);

    always_comb begin
        if (i_sensor_missing) begin
            o_state         = i_state;
            o_result.smoothed = i_state.filt;
            o_result.change   = '0;
            o_result.above    = i_state.high;
            o_result.err      = 1'b1;
        end else begin
            o_state.filt      = filt_new;
            o_state.have      = 1'b1;
            o_state.high      = high_new;
            o_result.smoothed = filt_new;
            o_result.change   = change_w[sttu_pkg::CHANGE_W-1:0];
            o_result.above    = high_new;
            o_result.err      = 1'b0;
        end
    end

endmodule
